>>> rtl/qkb_pkg.sv
// Shared types and constants for the quadrature knob with push button.
// No dependencies; imported by every module of the block.
package qkb_pkg;

    // Width of the microsecond time counters.
    localparam int TIME_BITS = 24;
    localparam int ELAPSED_W = 16;
    localparam int DEB_MS_W  = 10;
    localparam int HOLD_MS_W = 14;
    localparam int US_PER_MS = 1000;

    // Thresholds in microseconds; 1000 fits in 10 bits.
    localparam int DEB_THR_W  = DEB_MS_W + 10;
    localparam int HOLD_THR_W = HOLD_MS_W + 10;
    localparam int CMP_W      = (TIME_BITS > HOLD_THR_W) ? TIME_BITS : HOLD_THR_W;

    localparam logic [DEB_MS_W-1:0]  DEB_MS_RST  = DEB_MS_W'(20);
    localparam logic [HOLD_MS_W-1:0] HOLD_MS_RST = HOLD_MS_W'(1000);

    // Register indexes on the configuration port.
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_HOLD     = 1'b1;

    // Transition codes {previous AB, current AB}, both inverted.
    localparam logic [3:0] CW_CODE_0  = 4'b1101;
    localparam logic [3:0] CW_CODE_1  = 4'b0100;
    localparam logic [3:0] CW_CODE_2  = 4'b0010;
    localparam logic [3:0] CW_CODE_3  = 4'b1011;
    localparam logic [3:0] CCW_CODE_0 = 4'b1110;
    localparam logic [3:0] CCW_CODE_1 = 4'b0111;
    localparam logic [3:0] CCW_CODE_2 = 4'b0001;
    localparam logic [3:0] CCW_CODE_3 = 4'b1000;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic cw;
        logic ccw;
    } t_quad_flags;

    typedef struct packed {
        logic pressed;
        logic held;
        logic down;
    } t_btn_status;

    typedef struct packed {
        logic clear_pressed;
        logic clear_held;
    } t_btn_clear;

endpackage

>>> rtl/qkb_quad.sv
// Quadrature transition decoder with sticky direction flags.
// Depends on qkb_pkg.
module qkb_quad (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_a_level,
    input  logic               i_b_level,
    input  logic               i_clear_cw,
    input  logic               i_clear_ccw,
    output qkb_pkg::t_quad_flags o_flags
);
    import qkb_pkg::*;

    logic [1:0] r_last_ab;
    logic       r_cw;
    logic       r_ccw;
    logic [1:0] cur_ab;
    logic [3:0] code;
    logic       n_cw;
    logic       n_ccw;

    assign cur_ab = {~i_a_level, ~i_b_level};
    assign code   = {r_last_ab, cur_ab};

    always_comb begin
        n_cw  = r_cw;
        n_ccw = r_ccw;
        case (code) inside
            CW_CODE_0, CW_CODE_1, CW_CODE_2, CW_CODE_3: begin
                n_cw  = 1'b1;
                n_ccw = 1'b0;
            end
            CCW_CODE_0, CCW_CODE_1, CCW_CODE_2, CCW_CODE_3: begin
                n_cw  = 1'b0;
                n_ccw = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Flags as reported for this sample, before the clears apply.
    assign o_flags.cw  = n_cw;
    assign o_flags.ccw = n_ccw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab <= '0;
            r_cw      <= 1'b0;
            r_ccw     <= 1'b0;
        end else if (i_en) begin
            r_last_ab <= cur_ab;
            r_cw      <= n_cw & ~i_clear_cw;
            r_ccw     <= n_ccw & ~i_clear_ccw;
        end
    end

endmodule

>>> rtl/qkb_button.sv
// Button debouncer with press and long-hold detection.
// Depends on qkb_pkg; thresholds arrive already scaled to microseconds.
module qkb_button (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_button_level,
    input  logic [qkb_pkg::ELAPSED_W-1:0]     i_elapsed_us,
    input  qkb_pkg::t_btn_clear               i_clear,
    input  logic [qkb_pkg::DEB_THR_W-1:0]     i_deb_thr,
    input  logic [qkb_pkg::HOLD_THR_W-1:0]    i_hold_thr,
    output qkb_pkg::t_btn_status              o_status
);
    import qkb_pkg::*;

    logic                 r_last_reading;
    logic                 r_down;
    logic                 r_pressed;
    logic                 r_held;
    logic [TIME_BITS-1:0] r_stable_time;
    logic [TIME_BITS-1:0] r_press_time;

    logic                 reading;
    logic [TIME_BITS:0]   stable_sum;
    logic [TIME_BITS:0]   press_sum;
    logic [TIME_BITS-1:0] stable_sat;
    logic [TIME_BITS-1:0] press_sat;
    logic [TIME_BITS-1:0] n_stable_time;
    logic [TIME_BITS-1:0] n_press_time;
    logic                 accept_level;
    logic                 n_down;
    logic                 n_pressed;
    logic                 n_held;
    logic                 held_mid;

    assign reading    = ~i_button_level;
    assign stable_sum = {1'b0, r_stable_time} + (TIME_BITS+1)'(i_elapsed_us);
    assign press_sum  = {1'b0, r_press_time} + (TIME_BITS+1)'(i_elapsed_us);
    assign stable_sat = stable_sum[TIME_BITS] ? '1 : stable_sum[TIME_BITS-1:0];
    assign press_sat  = press_sum[TIME_BITS] ? '1 : press_sum[TIME_BITS-1:0];

    assign n_stable_time = (reading != r_last_reading) ? '0 : stable_sat;

    // A new level is taken once the reading has been stable past the threshold.
    assign accept_level = (CMP_W'(n_stable_time) > CMP_W'(i_deb_thr))
                        && (reading != r_down);

    assign n_down       = accept_level ? reading : r_down;
    assign n_pressed    = r_pressed | (accept_level & reading);
    assign n_press_time = (accept_level & reading) ? '0 : press_sat;
    assign held_mid     = accept_level ? 1'b0 : r_held;
    assign n_held       = held_mid
                        | (n_down & (CMP_W'(n_press_time) > CMP_W'(i_hold_thr)));

    assign o_status.pressed = n_pressed;
    assign o_status.held    = n_held;
    assign o_status.down    = n_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_reading <= 1'b0;
            r_down         <= 1'b0;
            r_pressed      <= 1'b0;
            r_held         <= 1'b0;
            r_stable_time  <= '0;
            r_press_time   <= '0;
        end else if (i_en) begin
            r_last_reading <= reading;
            r_down         <= n_down;
            r_pressed      <= n_pressed & ~i_clear.clear_pressed;
            r_held         <= n_held & ~i_clear.clear_held;
            r_stable_time  <= n_stable_time;
            r_press_time   <= n_press_time;
        end
    end

endmodule

>>> rtl/quadrature_knob_with_button.sv
// Top level of the quadrature knob with push button: stream ports,
// configuration registers and result register. Depends on qkb_pkg,
// qkb_quad and qkb_button.
//
//  Channel   Direction  Carries
//  s_*       in         one pin sample with elapsed time and flag clears
//  m_*       out        one result per sample: four flags and button state
//  APB       in/out     debounce_ms at 0x0, hold_ms at 0x4
//
// The state update and the result are formed in the cycle the request is
// accepted, and the result shows on m_* the next cycle. A new sample is
// accepted every cycle while the result register is empty or being drained,
// so throughput is one sample per clock. Reset is synchronous; it clears
// all state but the result data and restores the default thresholds.
// A stall on m_tready holds the result and stops intake only when the result
// register is still full.
module quadrature_knob_with_button (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from 0: a_level, b_level, button_level, elapsed_us[15:0],
    // clear_cw, clear_ccw, clear_pressed, clear_held, zero padding.
    input  logic [qkb_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from 0: cw_event, ccw_event, pressed_event, held_event,
    // button_down, zero padding.
    output logic [qkb_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import qkb_pkg::*;

    logic [DEB_MS_W-1:0]   r_debounce_ms;
    logic [HOLD_MS_W-1:0]  r_hold_ms;
    logic [DEB_THR_W-1:0]  r_deb_thr;
    logic [HOLD_THR_W-1:0] r_hold_thr;
    logic                  r_m_tvalid;
    logic [M_TDATA_W-1:0]  r_m_tdata;

    logic                  accept;
    logic                  cfg_write;
    t_quad_flags           quad_flags;
    t_btn_status           btn_status;
    t_btn_clear            btn_clear;

    // ---------------------------------------------------------------------
    // Configuration. The microsecond thresholds are scaled once, at write
    // time, so the per-sample path holds only adds and compares.
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEB_MS_RST;
            r_hold_ms     <= HOLD_MS_RST;
            r_deb_thr     <= DEB_THR_W'(DEB_MS_RST * US_PER_MS);
            r_hold_thr    <= HOLD_THR_W'(HOLD_MS_RST * US_PER_MS);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_DEBOUNCE: begin
                    r_debounce_ms <= pwdata[DEB_MS_W-1:0];
                    r_deb_thr     <= DEB_THR_W'(pwdata[DEB_MS_W-1:0] * US_PER_MS);
                end
                REG_HOLD: begin
                    r_hold_ms  <= pwdata[HOLD_MS_W-1:0];
                    r_hold_thr <= HOLD_THR_W'(pwdata[HOLD_MS_W-1:0] * US_PER_MS);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEBOUNCE: prdata = 32'(r_debounce_ms);
            REG_HOLD:     prdata = 32'(r_hold_ms);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sample path. The result register doubles as the skid stage: intake
    // continues whenever it is empty or drains in the same cycle.
    // ---------------------------------------------------------------------
    assign s_tready = ~r_m_tvalid | m_tready;
    assign accept   = s_tvalid & s_tready;

    assign btn_clear.clear_pressed = s_tdata[21];
    assign btn_clear.clear_held    = s_tdata[22];

    qkb_quad u_quad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_a_level   (s_tdata[0]),
        .i_b_level   (s_tdata[1]),
        .i_clear_cw  (s_tdata[19]),
        .i_clear_ccw (s_tdata[20]),
        .o_flags     (quad_flags)
    );

    qkb_button u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_button_level (s_tdata[2]),
        .i_elapsed_us   (s_tdata[18:3]),
        .i_clear        (btn_clear),
        .i_deb_thr      (r_deb_thr),
        .i_hold_thr     (r_hold_thr),
        .o_status       (btn_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (accept) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_tdata <= {3'b000, btn_status.down, btn_status.held,
                          btn_status.pressed, quad_flags.ccw, quad_flags.cw};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // ---------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------
    // Intake stalls only while a result waits on a stalled consumer.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("sample intake stalled without a pending result");

    // Every accepted sample produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted sample produced no result");

    // The two direction flags are mutually exclusive.
    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("clockwise and counter-clockwise both reported");

    // A long hold is only reported while the button is debounced down.
    a_held_needs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[3]) |-> m_tdata[4])
        else $error("held reported with the button released");

endmodule
